>>> hw/rtl/i2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Types, character codes, name table and helper functions shared by the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam int NUM_NAMES = 10;
  localparam int NAME_MAX  = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_NEG   = "~";
  localparam logic [7:0] CH_POW   = "^";
  localparam logic [7:0] CH_MUL   = "*";
  localparam logic [7:0] CH_DIV   = "/";
  localparam logic [7:0] CH_MOD   = "M";

  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd3
  };
  localparam logic [31:0] NAME_PACKED [NUM_NAMES] = '{
    32'h0073696E, 32'h00636F73, 32'h0074616E, 32'h6173696E, 32'h61636F73,
    32'h6174616E, 32'h73717274, 32'h00006C6E, 32'h006C6F67, 32'h006D6F64
  };
  localparam logic [7:0] NAME_CODE [NUM_NAMES] = '{
    "s", "c", "t", "S", "C", "T", "q", "l", "L", "M"
  };

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CLOSE    = 3'd1,
    ST_OPEN     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NAME     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    K_START, K_OPERAND, K_OPERATOR, K_OPEN, K_FUNC
  } kind_e;

  typedef enum logic [3:0] {
    CL_DIGIT, CL_LETTER, CL_OPERAND, CL_OPEN, CL_CLOSE,
    CL_PLUS, CL_MINUS, CL_OPER, CL_OTHER
  } class_e;

  typedef enum logic [2:0] {
    EM_NONE, EM_CHAR, EM_SPACE, EM_TOP, EM_END, EM_ERR
  } emit_e;

  typedef enum logic [1:0] {
    PUSH_CHAR, PUSH_OP, PUSH_FUNC
  } push_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PUSHOP, S_PUSHOP_SP, S_CLOSE, S_CLOSE_SP,
    S_CLOSE_FN, S_FN_SP, S_CHAR_SP, S_AFTER, S_FLUSH, S_FLUSH_SP,
    S_END, S_ERR
  } state_e;

  typedef struct packed {
    logic    load_in;
    emit_e   emit;
    status_e code;
    logic    pop;
    logic    push;
    push_e   push_sel;
    logic    load_op;
    logic    op_mod;
    logic    set_prev;
    kind_e   prev;
    logic    set_number;
    logic    clear_number;
    logic    take_letter;
    logic    set_error;
    logic    reset_all;
  } cmd_t;

  typedef struct packed {
    class_e cls;
    logic   last;
    logic   error_seen;
    logic   in_number;
    logic   name_pending;
    logic   unary;
    logic   lt_match;
    logic   lt_mod;
    logic   lt_full;
    logic   level_zero;
    logic   stack_full;
    logic   pop_ok;
    logic   top_open;
    logic   top_func;
    logic   out_free;
  } stat_t;

  function automatic logic [2:0] prio(logic [7:0] c);
    logic [2:0] p;
    case (c)
      CH_NEG:                 p = 3'd4;
      CH_POW:                 p = 3'd3;
      CH_MOD, CH_MUL, CH_DIV: p = 3'd2;
      CH_PLUS, CH_MINUS:      p = 3'd1;
      default:                p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_func(logic [7:0] c);
    logic f;
    case (c)
      "s", "c", "t", "S", "C", "T", "q", "l", "L": f = 1'b1;
      default:                                     f = 1'b0;
    endcase
    return f;
  endfunction

  function automatic class_e char_class(logic [7:0] c, logic name_pending);
    class_e k;
    if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
      k = CL_DIGIT;
    end else if (c >= CH_LA && c <= CH_LZ && !(c == CH_X && !name_pending)) begin
      k = CL_LETTER;
    end else begin
      case (c)
        CH_X, CH_BANG:          k = CL_OPERAND;
        CH_OPEN:                k = CL_OPEN;
        CH_CLOSE:               k = CL_CLOSE;
        CH_PLUS:                k = CL_PLUS;
        CH_MINUS:               k = CL_MINUS;
        CH_NEG, CH_MUL, CH_DIV,
        CH_POW:                 k = CL_OPER;
        default:                k = CL_OTHER;
      endcase
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/i2p_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_datapath
// Input holding register, operator stack, name buffer, parse flags and the
// output register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module i2p_datapath import i2p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic [2:0] status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic [7:0]       char_q;
  logic             last_q;
  logic [7:0]       op_q;
  logic [7:0]       stack_q [STACK_DEPTH];
  logic [LVL_W-1:0] level_q, level_d;
  kind_e            prev_q, prev_d;
  logic             number_q, number_d;
  logic [31:0]      name_q, name_d;
  logic [2:0]       name_len_q, name_len_d;
  logic             error_q, error_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic [2:0]       out_status_q;

  logic [LVL_W-1:0] level_dec;
  logic [7:0]       top;
  logic [7:0]       push_data;
  logic [31:0]      name_next;
  logic [2:0]       len_next;
  logic             lt_match;
  logic [7:0]       lt_code;
  logic [2:0]       pt, po;
  logic             op_right;

  assign level_dec = level_q - 1'b1;
  assign top       = stack_q[level_dec[IDX_W-1:0]];

  // name lookup on the buffer with the current letter appended
  assign name_next = {name_q[23:0], char_q};
  assign len_next  = name_len_q + 3'd1;

  always_comb begin
    lt_match = 1'b0;
    lt_code  = CH_NUL;
    for (int i = 0; i < NUM_NAMES; i++) begin
      if (NAME_LEN[i] == len_next && NAME_PACKED[i] == name_next) begin
        lt_match = 1'b1;
        lt_code  = NAME_CODE[i];
      end
    end
  end

  assign pt       = prio(top);
  assign po       = prio(op_q);
  assign op_right = (op_q == CH_NEG) || (op_q == CH_POW);

  always_comb begin
    stat_o.cls          = char_class(char_q, name_len_q != 3'd0);
    stat_o.last         = last_q;
    stat_o.error_seen   = error_q;
    stat_o.in_number    = number_q;
    stat_o.name_pending = name_len_q != 3'd0;
    stat_o.unary        = prev_q != K_OPERAND;
    stat_o.lt_match     = lt_match;
    stat_o.lt_mod       = lt_match && (lt_code == CH_MOD);
    stat_o.lt_full      = len_next >= 3'(NAME_MAX);
    stat_o.level_zero   = level_q == '0;
    stat_o.stack_full   = level_q >= LVL_W'(STACK_DEPTH);
    stat_o.pop_ok       = (level_q != '0) && (pt != 3'd0) &&
                          ((pt > po) || (pt == po && !op_right));
    stat_o.top_open     = top == CH_OPEN;
    stat_o.top_func     = is_func(top);
    stat_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // input holding and pending operator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
    if (cmd_i.load_op) begin
      if (cmd_i.op_mod) begin
        op_q <= CH_MOD;
      end else if (char_q == CH_MINUS && prev_q != K_OPERAND) begin
        op_q <= CH_NEG;
      end else begin
        op_q <= char_q;
      end
    end
  end

  always_comb begin
    case (cmd_i.push_sel)
      PUSH_OP:   push_data = op_q;
      PUSH_FUNC: push_data = lt_code;
      default:   push_data = char_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[level_q[IDX_W-1:0]] <= push_data;
    end
  end

  always_comb begin
    level_d    = level_q;
    prev_d     = prev_q;
    number_d   = number_q;
    name_d     = name_q;
    name_len_d = name_len_q;
    error_d    = error_q;
    if (cmd_i.pop) begin
      level_d = level_dec;
    end else if (cmd_i.push) begin
      level_d = level_q + 1'b1;
    end
    if (cmd_i.set_prev) begin
      prev_d = cmd_i.prev;
    end
    if (cmd_i.set_number) begin
      number_d = 1'b1;
    end else if (cmd_i.clear_number) begin
      number_d = 1'b0;
    end
    if (cmd_i.take_letter) begin
      if (lt_match) begin
        name_d     = '0;
        name_len_d = '0;
      end else begin
        name_d     = name_next;
        name_len_d = len_next;
      end
    end
    if (cmd_i.set_error) begin
      error_d = 1'b1;
    end
    if (cmd_i.reset_all) begin
      level_d    = '0;
      prev_d     = K_START;
      number_d   = 1'b0;
      name_d     = '0;
      name_len_d = '0;
      error_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      prev_q     <= K_START;
      number_q   <= 1'b0;
      name_q     <= '0;
      name_len_q <= '0;
      error_q    <= 1'b0;
    end else begin
      level_q    <= level_d;
      prev_q     <= prev_d;
      number_q   <= number_d;
      name_q     <= name_d;
      name_len_q <= name_len_d;
      error_q    <= error_d;
    end
  end

  // output register, one character per transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit != EM_NONE) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      EM_CHAR: begin
        out_char_q   <= char_q;
        out_last_q   <= 1'b0;
        out_status_q <= ST_OK;
      end
      EM_SPACE: begin
        out_char_q   <= CH_SPACE;
        out_last_q   <= 1'b0;
        out_status_q <= ST_OK;
      end
      EM_TOP: begin
        out_char_q   <= top;
        out_last_q   <= 1'b0;
        out_status_q <= ST_OK;
      end
      EM_END: begin
        out_char_q   <= CH_NUL;
        out_last_q   <= 1'b1;
        out_status_q <= ST_OK;
      end
      EM_ERR: begin
        out_char_q   <= CH_NUL;
        out_last_q   <= 1'b1;
        out_status_q <= cmd_i.code;
      end
      default: begin
        out_char_q   <= out_char_q;
        out_last_q   <= out_last_q;
        out_status_q <= out_status_q;
      end
    endcase
  end

  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign status_o    = out_status_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/i2p_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer for the converter: takes one character, then walks the
// shunting-yard steps one stack operation or output character per cycle while the output is free.
// ----------------------------------------------------------------------------
module i2p_ctrl import i2p_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e err_q, err_d;
  logic    free;

  assign free = stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.error_seen) begin
          state_d = S_IDLE;
        end else if (stat_i.cls == CL_DIGIT) begin
          if (stat_i.name_pending) begin
            err_d   = ST_NAME;
            state_d = S_ERR;
          end else if (free) begin
            state_d = S_AFTER;
          end
        end else if (stat_i.in_number) begin
          state_d = S_DISPATCH;
        end else if (stat_i.cls == CL_LETTER) begin
          if (stat_i.lt_match) begin
            if (stat_i.lt_mod) begin
              state_d = S_PUSHOP;
            end else if (stat_i.stack_full) begin
              err_d   = ST_OVERFLOW;
              state_d = S_ERR;
            end else begin
              state_d = S_AFTER;
            end
          end else if (stat_i.lt_full) begin
            err_d   = ST_NAME;
            state_d = S_ERR;
          end else begin
            state_d = S_AFTER;
          end
        end else if (stat_i.name_pending) begin
          err_d   = ST_NAME;
          state_d = S_ERR;
        end else begin
          case (stat_i.cls)
            CL_OPERAND: begin
              if (free) begin
                state_d = S_CHAR_SP;
              end
            end
            CL_OPEN: begin
              if (stat_i.stack_full) begin
                err_d   = ST_OVERFLOW;
                state_d = S_ERR;
              end else begin
                state_d = S_AFTER;
              end
            end
            CL_CLOSE: state_d = S_CLOSE;
            CL_PLUS:  state_d = stat_i.unary ? S_AFTER : S_PUSHOP;
            CL_MINUS, CL_OPER: state_d = S_PUSHOP;
            default:  state_d = S_AFTER;
          endcase
        end
      end
      S_PUSHOP: begin
        if (stat_i.pop_ok) begin
          if (free) begin
            state_d = S_PUSHOP_SP;
          end
        end else if (stat_i.stack_full) begin
          err_d   = ST_OVERFLOW;
          state_d = S_ERR;
        end else begin
          state_d = S_AFTER;
        end
      end
      S_PUSHOP_SP: begin
        if (free) begin
          state_d = S_PUSHOP;
        end
      end
      S_CLOSE: begin
        if (stat_i.level_zero) begin
          err_d   = ST_CLOSE;
          state_d = S_ERR;
        end else if (!stat_i.top_open) begin
          if (free) begin
            state_d = S_CLOSE_SP;
          end
        end else begin
          state_d = S_CLOSE_FN;
        end
      end
      S_CLOSE_SP: begin
        if (free) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE_FN: begin
        if (!stat_i.level_zero && stat_i.top_func) begin
          if (free) begin
            state_d = S_FN_SP;
          end
        end else begin
          state_d = S_AFTER;
        end
      end
      S_FN_SP, S_CHAR_SP: begin
        if (free) begin
          state_d = S_AFTER;
        end
      end
      S_AFTER: begin
        state_d = stat_i.last ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (stat_i.in_number) begin
          state_d = S_FLUSH;
        end else if (stat_i.name_pending) begin
          err_d   = ST_NAME;
          state_d = S_ERR;
        end else if (!stat_i.level_zero) begin
          if (stat_i.top_open) begin
            err_d   = ST_OPEN;
            state_d = S_ERR;
          end else if (free) begin
            state_d = S_FLUSH_SP;
          end
        end else begin
          state_d = S_END;
        end
      end
      S_FLUSH_SP: begin
        if (free) begin
          state_d = S_FLUSH;
        end
      end
      S_END, S_ERR: begin
        if (free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.emit = EM_NONE;
    cmd_o.code = ST_OK;
    in_stall_o = state_q != S_IDLE;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
      end
      S_DISPATCH: begin
        if (stat_i.error_seen) begin
          // characters after a fault are dropped until the end marker
          cmd_o.reset_all = stat_i.last;
        end else if (stat_i.cls == CL_DIGIT) begin
          if (!stat_i.name_pending && free) begin
            cmd_o.emit       = EM_CHAR;
            cmd_o.set_number = 1'b1;
            cmd_o.set_prev   = 1'b1;
            cmd_o.prev       = K_OPERAND;
          end
        end else if (stat_i.in_number) begin
          // number ends here
          if (free) begin
            cmd_o.emit         = EM_SPACE;
            cmd_o.clear_number = 1'b1;
          end
        end else if (stat_i.cls == CL_LETTER) begin
          cmd_o.take_letter = 1'b1;
          if (stat_i.lt_match) begin
            if (stat_i.lt_mod) begin
              cmd_o.load_op = 1'b1;
              cmd_o.op_mod  = 1'b1;
            end else if (!stat_i.stack_full) begin
              cmd_o.push     = 1'b1;
              cmd_o.push_sel = PUSH_FUNC;
              cmd_o.set_prev = 1'b1;
              cmd_o.prev     = K_FUNC;
            end
          end
        end else if (!stat_i.name_pending) begin
          case (stat_i.cls)
            CL_OPERAND: begin
              if (free) begin
                cmd_o.emit     = EM_CHAR;
                cmd_o.set_prev = 1'b1;
                cmd_o.prev     = K_OPERAND;
              end
            end
            CL_OPEN: begin
              if (!stat_i.stack_full) begin
                cmd_o.push     = 1'b1;
                cmd_o.push_sel = PUSH_CHAR;
                cmd_o.set_prev = 1'b1;
                cmd_o.prev     = K_OPEN;
              end
            end
            CL_PLUS: begin
              if (stat_i.unary) begin
                cmd_o.set_prev = 1'b1;
                cmd_o.prev     = K_OPERATOR;
              end else begin
                cmd_o.load_op = 1'b1;
              end
            end
            CL_MINUS, CL_OPER: begin
              cmd_o.load_op = 1'b1;
            end
            default: begin
              cmd_o.load_op = 1'b0;
            end
          endcase
        end
      end
      S_PUSHOP: begin
        if (stat_i.pop_ok) begin
          if (free) begin
            cmd_o.emit = EM_TOP;
            cmd_o.pop  = 1'b1;
          end
        end else begin
          cmd_o.set_prev = 1'b1;
          cmd_o.prev     = K_OPERATOR;
          if (!stat_i.stack_full) begin
            cmd_o.push     = 1'b1;
            cmd_o.push_sel = PUSH_OP;
          end
        end
      end
      S_CLOSE: begin
        if (!stat_i.level_zero) begin
          if (!stat_i.top_open) begin
            if (free) begin
              cmd_o.emit = EM_TOP;
              cmd_o.pop  = 1'b1;
            end
          end else begin
            // drop the matching open parenthesis
            cmd_o.pop = 1'b1;
          end
        end
      end
      S_CLOSE_FN: begin
        if (!stat_i.level_zero && stat_i.top_func) begin
          if (free) begin
            cmd_o.emit     = EM_TOP;
            cmd_o.pop      = 1'b1;
            cmd_o.set_prev = 1'b1;
            cmd_o.prev     = K_OPERAND;
          end
        end else begin
          cmd_o.set_prev = 1'b1;
          cmd_o.prev     = K_OPERAND;
        end
      end
      S_PUSHOP_SP, S_CLOSE_SP, S_FN_SP, S_CHAR_SP, S_FLUSH_SP: begin
        if (free) begin
          cmd_o.emit = EM_SPACE;
        end
      end
      S_FLUSH: begin
        if (stat_i.in_number) begin
          if (free) begin
            cmd_o.emit         = EM_SPACE;
            cmd_o.clear_number = 1'b1;
          end
        end else if (!stat_i.name_pending && !stat_i.level_zero && !stat_i.top_open) begin
          if (free) begin
            cmd_o.emit = EM_TOP;
            cmd_o.pop  = 1'b1;
          end
        end
      end
      S_END: begin
        if (free) begin
          cmd_o.emit      = EM_END;
          cmd_o.reset_all = 1'b1;
        end
      end
      S_ERR: begin
        if (free) begin
          cmd_o.emit      = EM_ERR;
          cmd_o.code      = err_q;
          cmd_o.set_error = 1'b1;
          cmd_o.reset_all = stat_i.last;
        end
      end
      default: begin
        cmd_o.load_in = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Streaming shunting-yard converter from infix text to postfix text.
// ----------------------------------------------------------------------------
// One infix character is taken per input transfer and the postfix text comes
// out one character per output transfer, every token followed by a space; an
// item marked last flushes the operator stack and closes with a zero
// character flagged last, or a fault ends the expression early with a
// status code. A sequencer handles one character at a time and takes no new
// input until it is done; the output register moves one character a cycle
// while the output is not stalled. A character that ends a number first
// writes the number's space. An operator or a completed mod pops and writes
// out, each with its space, every stacked operator that goes first by
// priority and associativity, then is pushed; a closing parenthesis pops
// and writes out operators down to the open parenthesis, drops it, and then
// writes out a function that sits under it. A character marked last then
// ends a pending number, flushes the stack operator by operator until it is
// empty and writes the closing character. A fault writes the status
// character, and later characters up to the end marker are dropped. A
// stalled output holds the sequencer where it stands. The operator stack
// lives in flip-flops indexed by the fill level, so no clearing pass is
// needed after reset.
module infix_to_postfix_converter import i2p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic [2:0] status_o
);

  cmd_t  cmd;
  stat_t stat;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  i2p_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
